/* hdl/aeskx_pkg.sv */
// Shared types, S-box table and round-constant function for the AES-128 key expansion.
package aeskx_pkg;

    typedef struct packed {
        logic         valid;
        logic [127:0] key;
    } aeskx_stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] GF_POLY_LOW = 8'h1b;

    // Round constant x^(round-1) in GF(2^8), evaluated at elaboration for each cell.
    function automatic logic [7:0] aeskx_rcon(input int round);
        logic [7:0] rc;
        rc = 8'h01;
        for (int i = 1; i < round; i++)
        begin
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? GF_POLY_LOW : 8'h00);
        end
        return rc;
    endfunction

endpackage

/* hdl/aeskx_key_if.sv */
// Valid/ready channel that carries one 128-bit cipher key per item.
interface aeskx_key_if;
    logic        valid;
    logic        ready;
    logic [63:0] key_high;
    logic [63:0] key_low;

    modport source (output valid, output key_high, output key_low, input ready);
    modport sink (input valid, input key_high, input key_low, output ready);
endinterface

/* hdl/aeskx_rk_if.sv */
// Valid/ready channel that carries one round key per item.
interface aeskx_rk_if;
    logic        valid;
    logic        ready;
    logic [63:0] round_key_high;
    logic [63:0] round_key_low;
    logic [3:0]  round_number;
    logic        final_round;

    modport source (output valid, output round_key_high, output round_key_low,
                    output round_number, output final_round, input ready);
    modport sink (input valid, input round_key_high, input round_key_low,
                  input round_number, input final_round, output ready);
endinterface

/* hdl/aes128_key_expansion.sv */
// Top level of the AES-128 key expansion: input buffer, chain of round cells, result select.
// A key item is held in a one-item input buffer and then walks a chain of round cells,
// one cell per cycle while the sink is ready; the cell it occupies presents that round
// key as a result item, so the eleven round keys of a key leave in order, round 0
// through round 10, one per cycle while the sink is ready, with round 10 flagged as
// final. When the chain is empty, an accepted key is registered in the input buffer and
// then in stage 0, whose output is the first result. A key walks the chain alone; the
// next key waits in the input buffer and enters the chain in the cycle its predecessor's
// final round key is taken.
module aes128_key_expansion import aeskx_pkg::*;
#(
    parameter int ROUND_COUNT = 10
)
(
    input logic         clk,
    input logic         rst_n,
    aeskx_key_if.sink   key,
    aeskx_rk_if.source  round_key
);

    localparam int STAGE_COUNT = ROUND_COUNT + 1;
    localparam int IDX_W = $clog2(STAGE_COUNT);

    aeskx_stage_t             stage [STAGE_COUNT];
    aeskx_stage_t             stage0_reg;
    aeskx_stage_t             stage0_next;
    logic                     buf_valid_reg;
    logic                     buf_valid_next;
    logic [127:0]             buf_key_reg;
    logic [STAGE_COUNT-1:0]   stage_valid;
    logic                     any_valid;
    logic                     chain_free;
    logic                     advance;
    logic                     load0;
    logic [127:0]             sel_key;
    logic [IDX_W-1:0]         sel_idx;

    assign stage[0] = stage0_reg;

    for (genvar k = 1; k < STAGE_COUNT; k++)
    begin : g_cell
        aeskx_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .rcon    (aeskx_rcon(k)),
            .prev    (stage[k-1]),
            .stage   (stage[k])
        );
    end

    always_comb
    begin
        for (int k = 0; k < STAGE_COUNT; k++)
        begin
            stage_valid[k] = stage[k].valid;
        end
    end

    assign any_valid  = |stage_valid;
    assign chain_free = ~|stage_valid[STAGE_COUNT-2:0];
    assign advance    = !any_valid || round_key.ready;
    assign load0      = advance && chain_free && buf_valid_reg;
    assign key.ready  = !buf_valid_reg;

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        if (load0)
        begin
            buf_valid_next = 1'b0;
        end
        if (key.valid && key.ready)
        begin
            buf_valid_next = 1'b1;
        end
        stage0_next = stage0_reg;
        if (advance)
        begin
            stage0_next.valid = load0;
            stage0_next.key   = buf_key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            stage0_reg    <= '0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            stage0_reg    <= stage0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key.valid && key.ready)
        begin
            buf_key_reg <= {key.key_high, key.key_low};
        end
    end

    // At most one cell holds a key, so the select is a plain OR of the gated cells.
    always_comb
    begin
        sel_key = '0;
        sel_idx = '0;
        for (int k = 0; k < STAGE_COUNT; k++)
        begin
            if (stage_valid[k])
            begin
                sel_key = sel_key | stage[k].key;
                sel_idx = sel_idx | IDX_W'(k);
            end
        end
    end

    assign round_key.valid          = any_valid;
    assign round_key.round_key_high = sel_key[127:64];
    assign round_key.round_key_low  = sel_key[63:0];
    assign round_key.round_number   = 4'(sel_idx);
    assign round_key.final_round    = stage_valid[STAGE_COUNT-1];

    a_single_key: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(stage_valid))
        else $error("more than one key in the round chain");

    a_round_order: assert property (@(posedge clk) disable iff (!rst_n)
        (round_key.valid && round_key.ready && !round_key.final_round)
        |=> (round_key.valid && round_key.round_number == $past(round_key.round_number) + 4'd1))
        else $error("round keys not delivered in consecutive order");

    a_buffer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_valid_reg && !any_valid) |=> (stage0_reg.valid && !buf_valid_reg))
        else $error("buffered key did not enter the empty chain");

    a_start_round: assert property (@(posedge clk) disable iff (!rst_n)
        (round_key.valid && !$past(round_key.valid)) |-> (round_key.round_number == 4'd0))
        else $error("result run did not start at round zero");

endmodule

/* hdl/aeskx_cell.sv */
// One round cell: derives the next round key from its neighbor and holds it.
module aeskx_cell import aeskx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic [7:0]   rcon,
    input  aeskx_stage_t prev,
    output aeskx_stage_t stage
);

    aeskx_stage_t stage_reg;
    aeskx_stage_t stage_next;
    logic [31:0]  w0, w1, w2, w3;
    logic [31:0]  rot_sub;
    logic [31:0]  n0, n1, n2, n3;

    always_comb
    begin
        w0 = prev.key[127:96];
        w1 = prev.key[95:64];
        w2 = prev.key[63:32];
        w3 = prev.key[31:0];
        rot_sub = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        n0 = w0 ^ rot_sub ^ {rcon, 24'h000000};
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        stage_next = stage_reg;
        if (advance)
        begin
            stage_next.valid = prev.valid;
            stage_next.key   = {n0, n1, n2, n3};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule
